### sv/pgh_pkg.sv
package pgh_pkg;

  // The histogram has one bin for each value of an 8-bit gray level.
  localparam int BIN_COUNT = 256;
  localparam int BIN_BITS  = 8;

  // Bytes of the PGM header that the parser looks for.
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_FIVE    = 8'h35;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Item kinds on the input channel.
  localparam logic MODE_FILE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Status codes carried by every result.
  localparam logic [1:0] ST_HEADER = 2'd0;
  localparam logic [1:0] ST_PIXELS = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_BAD    = 2'd3;

  // Control from the parser to the bin store for one file byte.
  typedef struct packed {
    logic clear;  // A new file starts, so all bins return to zero.
    logic count;  // This byte is a pixel and its bin is incremented.
  } pgh_ctrl_t;

endpackage

### sv/pgh_parser.sv
module pgh_parser import pgh_pkg::*; #(
  parameter int DIM_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                file_start,
  input  logic                file_end,
  output pgh_ctrl_t           ctrl,
  output logic [1:0]          status_next,
  output logic [DIM_BITS-1:0] width_next,
  output logic [DIM_BITS-1:0] height_next
);

  localparam int PL_BITS = 2 * DIM_BITS;

  localparam logic [3:0] PH_MAGIC1 = 4'd0;
  localparam logic [3:0] PH_MAGIC2 = 4'd1;
  localparam logic [3:0] PH_SEP    = 4'd2;
  localparam logic [3:0] PH_WIDTH  = 4'd3;
  localparam logic [3:0] PH_HEIGHT = 4'd4;
  localparam logic [3:0] PH_MAXVAL = 4'd5;
  localparam logic [3:0] PH_PIXELS = 4'd6;
  localparam logic [3:0] PH_DONE   = 4'd7;
  localparam logic [3:0] PH_BAD    = 4'd8;

  logic [3:0]          phase;
  logic [3:0]          phase_next;
  logic [DIM_BITS-1:0] width;
  logic [DIM_BITS-1:0] height;
  logic [PL_BITS-1:0]  pixels_left;
  logic [PL_BITS-1:0]  pixels_left_next;
  logic                is_digit;
  logic                count_flag;
  logic [PL_BITS-1:0]  area;

  // Decimal accumulate that sticks at the largest value the width can hold.
  function automatic logic [DIM_BITS-1:0] add_digit(input logic [DIM_BITS-1:0] acc,
                                                   input logic [3:0] digit);
    logic [DIM_BITS+3:0] ext;
    logic [DIM_BITS+3:0] sum;
    ext = {4'b0000, acc};
    sum = (ext << 3) + (ext << 1) + {{DIM_BITS{1'b0}}, digit};
    if (sum[DIM_BITS+3:DIM_BITS] != 4'b0000) begin
      return {DIM_BITS{1'b1}};
    end
    return sum[DIM_BITS-1:0];
  endfunction

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign area = {{DIM_BITS{1'b0}}, width} * {{DIM_BITS{1'b0}}, height};

  always_comb begin
    phase_next       = phase;
    width_next       = width;
    height_next      = height;
    pixels_left_next = pixels_left;
    count_flag       = 1'b0;
    if (step) begin
      if (file_start) begin
        phase_next       = PH_MAGIC1;
        width_next       = '0;
        height_next      = '0;
        pixels_left_next = '0;
      end
      unique case (phase_next)
        PH_MAGIC1: phase_next = (data_byte == CH_P) ? PH_MAGIC2 : PH_BAD;
        PH_MAGIC2: phase_next = (data_byte == CH_FIVE) ? PH_SEP : PH_BAD;
        PH_SEP:    phase_next = PH_WIDTH;
        PH_WIDTH: begin
          if (data_byte == CH_SPACE) begin
            phase_next = PH_HEIGHT;
          end else if (is_digit) begin
            width_next = add_digit(width_next, data_byte[3:0]);
          end
        end
        PH_HEIGHT: begin
          if (data_byte == CH_NEWLINE) begin
            phase_next = PH_MAXVAL;
          end else if (is_digit) begin
            height_next = add_digit(height_next, data_byte[3:0]);
          end
        end
        PH_MAXVAL: begin
          // A start byte never lands here, so the stored sizes are current.
          if (data_byte == CH_NEWLINE) begin
            pixels_left_next = area;
            phase_next = (area != '0) ? PH_PIXELS : PH_DONE;
          end
        end
        PH_PIXELS: begin
          count_flag       = 1'b1;
          pixels_left_next = pixels_left_next - 1'b1;
          if (pixels_left_next == '0) begin
            phase_next = PH_DONE;
          end
        end
        default: ;
      endcase
      if (file_end) begin
        if (phase_next == PH_MAGIC1 || phase_next == PH_MAGIC2) begin
          phase_next = PH_BAD;
        end else if (phase_next != PH_BAD) begin
          phase_next = PH_DONE;
        end
      end
    end
  end

  always_comb begin
    unique case (phase_next)
      PH_PIXELS: status_next = ST_PIXELS;
      PH_DONE:   status_next = ST_DONE;
      PH_BAD:    status_next = ST_BAD;
      default:   status_next = ST_HEADER;
    endcase
  end

  assign ctrl.clear = step && file_start;
  assign ctrl.count = count_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC1;
      width       <= '0;
      height      <= '0;
      pixels_left <= '0;
    end else begin
      phase       <= phase_next;
      width       <= width_next;
      height      <= height_next;
      pixels_left <= pixels_left_next;
    end
  end

`ifndef SYNTHESIS
  a_no_count_on_clear: assert property (@(posedge clk) disable iff (rst)
    ctrl.count |-> !ctrl.clear)
    else $error("pixel counted on the byte that starts a file");

  a_pixels_need_budget: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) |-> (pixels_left != '0))
    else $error("counting pixels with no pixels left");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && !(step && file_start)) |=> (phase == PH_DONE))
    else $error("finished file left done without a new file");

  a_bad_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BAD && !(step && file_start)) |=> (phase == PH_BAD))
    else $error("rejected file left the bad state without a new file");
`endif

endmodule

### sv/pgh_bins.sv
module pgh_bins import pgh_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [BIN_BITS-1:0]   rd_addr,
  input  pgh_ctrl_t             ctrl,
  input  logic [BIN_BITS-1:0]   wr_addr,
  output logic [COUNT_BITS-1:0] rd_count
);

  logic [COUNT_BITS-1:0] mem [BIN_COUNT];
  logic [BIN_COUNT-1:0]  bin_valid;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  hit;
  logic [COUNT_BITS-1:0] hit_data;
  logic                  stale;
  logic [COUNT_BITS-1:0] wr_data;

  // The read is issued when an item is taken in; a write landing on the same
  // bin at that edge is forwarded, and a clear at that edge zeroes the read.
  assign rd_count = hit ? hit_data : (stale ? '0 : rd_data);
  assign wr_data  = (&rd_count) ? rd_count : rd_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (ctrl.count) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit      <= ctrl.count && (wr_addr == rd_addr);
      hit_data <= wr_data;
      stale    <= ctrl.clear || !bin_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      bin_valid <= '0;
    end else if (ctrl.count) begin
      bin_valid[wr_addr] <= 1'b1;
    end
  end

endmodule

### sv/pgm_gray_histogram.sv
// Histogram of an 8-bit binary PGM (P5) image, fed one file byte per
// transfer. A file byte item (mode 0) runs the header parser: magic "P5",
// one separator byte, decimal width ended by a space, decimal height ended
// by a newline, a skipped max-value line, then width*height pixel bytes
// counted into 256 saturating bins; file_start on a byte clears the parser
// and the histogram, and file_end closes the file early. A read item
// (mode 1) returns the count of bin bin_index and changes nothing. Every
// item gives exactly one result carrying the status and sizes after it.
// The block takes one item per clock while the result can move on; a stalled
// output holds the work stage and with it the input. The registered bin memory
// read is issued at the edge that takes the item into the work stage, and the
// parse and the bin update go into the result register at the edge where the
// work stage moves on. Back-to-back pixels of the same gray level are
// forwarded around the memory, so no bubbles are needed.
module pgm_gray_histogram import pgh_pkg::*; #(
  parameter int COUNT_BITS = 32,
  parameter int DIM_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic [7:0]            data_byte,
  input  logic                  file_start,
  input  logic                  file_end,
  input  logic [7:0]            bin_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [DIM_BITS-1:0]   image_width,
  output logic [DIM_BITS-1:0]   image_height,
  output logic [COUNT_BITS-1:0] bin_count,
  output logic                  read_valid
);

  // Work stage: holds the taken item while its bin read completes.
  logic                  s1_valid;
  logic                  s1_mode;
  logic [7:0]            s1_byte;
  logic                  s1_start;
  logic                  s1_end;

  logic                  in_take;
  logic                  s1_adv;
  logic                  step;
  pgh_ctrl_t             ctrl;
  logic [1:0]            status_next;
  logic [DIM_BITS-1:0]   width_next;
  logic [DIM_BITS-1:0]   height_next;
  logic [COUNT_BITS-1:0] rd_count;
  logic [BIN_BITS-1:0]   rd_addr;

  // The result register frees up when it is empty or its transfer completes.
  // The work stage can take a new item whenever it is empty or moving on,
  // so a waiting result blocks the input only once the work stage also
  // holds an item.
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_take  = in_valid && in_ready;
  assign step     = s1_adv && (s1_mode == MODE_FILE);

  // A read item looks up its requested bin; a file byte looks up its own
  // value in case it turns out to be a pixel.
  assign rd_addr = (mode == MODE_READ) ? bin_index : data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode  <= mode;
      s1_byte  <= data_byte;
      s1_start <= file_start;
      s1_end   <= file_end;
    end
  end

  pgh_parser #(
    .DIM_BITS(DIM_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (s1_byte),
    .file_start (s1_start),
    .file_end   (s1_end),
    .ctrl       (ctrl),
    .status_next(status_next),
    .width_next (width_next),
    .height_next(height_next)
  );

  pgh_bins #(
    .COUNT_BITS(COUNT_BITS)
  ) u_bins (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_take),
    .rd_addr (rd_addr),
    .ctrl    (ctrl),
    .wr_addr (s1_byte),
    .rd_count(rd_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The status and sizes are the parser state after this item is applied;
  // a read item leaves that state as it was.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status       <= status_next;
      image_width  <= width_next;
      image_height <= height_next;
      bin_count    <= (s1_mode == MODE_READ) ? rd_count : '0;
      read_valid   <= s1_mode;
    end
  end

endmodule

### bench/tb_pgm_gray_histogram.sv
// Self-checking bench for the PGM gray-level histogram block.
//
// File bytes and bin reads are pushed through the input valid/ready channel
// one transfer at a time. At each accepted transfer the bench's own parser
// and histogram are stepped, and the reply the block owes is queued. A
// monitor pops the oldest queued reply for each result transfer and compares
// every field of it. Directed tests come first, then random files under four
// idle/stall settings.
module tb_pgm_gray_histogram import pgh_pkg::*;;

  localparam int DIM_W       = 16;
  localparam int CNT_W       = 32;
  localparam int CYCLE_LIMIT = 200000;

  // Parser position inside one file. Header states come first, so the
  // status field reads "header" for all of them.
  typedef enum logic [3:0] {
    HDR_P, HDR_FIVE, HDR_SEP, HDR_WIDTH, HDR_HEIGHT, HDR_MAXVAL,
    IMG_PIXELS, IMG_DONE, IMG_BAD
  } parse_state_e;

  // One result transfer as the block must present it.
  typedef struct {
    logic [1:0]       status;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [CNT_W-1:0] count;
    logic             is_read;
  } hist_reply_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic             mode;
  logic [7:0]       data_byte;
  logic             file_start;
  logic             file_end;
  logic [7:0]       bin_index;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       status;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [CNT_W-1:0] bin_count;
  logic             read_valid;

  // Bench copy of the block's state.
  parse_state_e     exp_state;
  logic [DIM_W-1:0] exp_width;
  logic [DIM_W-1:0] exp_height;
  logic [31:0]      exp_pixels_left;
  logic [CNT_W-1:0] exp_bins [BIN_COUNT];

  hist_reply_t      hist_reply_q [$];
  logic [7:0]       file_bytes [$];

  int idle_pct    = 0;
  int stall_pct   = 0;
  int sent_count  = 0;
  int fail_count  = 0;
  int cycle_count = 0;

  pgm_gray_histogram #(
    .COUNT_BITS(CNT_W),
    .DIM_BITS  (DIM_W)
  ) i_dut (
    .clk, .rst,
    .in_valid, .in_ready, .mode, .data_byte, .file_start, .file_end, .bin_index,
    .out_valid, .out_ready, .status, .image_width, .image_height, .bin_count,
    .read_valid
  );

  // Clock: low half first, period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pgm_gray_histogram regression: fail");
      $finish;
    end
  end

  task automatic log_fail(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // A new file or a reset wipes the parser, both sizes and every bin.
  task automatic clear_file_state();
    exp_state       = HDR_P;
    exp_width       = '0;
    exp_height      = '0;
    exp_pixels_left = '0;
    foreach (exp_bins[i]) exp_bins[i] = '0;
  endtask

  // A decimal digit is shifted into a size, which sticks at all ones once it
  // overflows.
  function automatic logic [DIM_W-1:0] push_digit(input logic [DIM_W-1:0] acc,
                                                   input logic [7:0] ch);
    logic [31:0] v;
    v = 32'(acc) * 10 + {24'd0, ch - CH_ZERO};
    return (v > 32'((1 << DIM_W) - 1)) ? '1 : v[DIM_W-1:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  // Steps the bench's parser and histogram for one accepted item and queues
  // the reply that the block must give for it.
  task automatic predict_histogram(input logic m, input logic [7:0] b, input logic s,
                                   input logic e, input logic [7:0] idx);
    hist_reply_t r;
    r.count = '0;
    if (m == MODE_FILE) begin
      if (s) clear_file_state();
      case (exp_state)
        HDR_P:    exp_state = (b == CH_P) ? HDR_FIVE : IMG_BAD;
        HDR_FIVE: exp_state = (b == CH_FIVE) ? HDR_SEP : IMG_BAD;
        // Whatever byte follows the magic is taken as the separator.
        HDR_SEP:  exp_state = HDR_WIDTH;
        HDR_WIDTH: begin
          if (b == CH_SPACE) exp_state = HDR_HEIGHT;
          else if (is_digit(b)) exp_width = push_digit(exp_width, b);
        end
        HDR_HEIGHT: begin
          if (b == CH_NEWLINE) exp_state = HDR_MAXVAL;
          else if (is_digit(b)) exp_height = push_digit(exp_height, b);
        end
        HDR_MAXVAL: begin
          if (b == CH_NEWLINE) begin
            exp_pixels_left = 32'(exp_width) * 32'(exp_height);
            exp_state = (exp_pixels_left != 0) ? IMG_PIXELS : IMG_DONE;
          end
        end
        IMG_PIXELS: begin
          if (exp_bins[b] != '1) exp_bins[b] = exp_bins[b] + 1'b1;
          exp_pixels_left = exp_pixels_left - 1;
          if (exp_pixels_left == 0) exp_state = IMG_DONE;
        end
        default: ;
      endcase
      // End of file: still inside the magic means it was never a PGM file,
      // anywhere else past a good magic the file is simply done.
      if (e) begin
        if (exp_state inside {HDR_P, HDR_FIVE}) exp_state = IMG_BAD;
        else if (exp_state != IMG_BAD) exp_state = IMG_DONE;
      end
    end else begin
      r.count = exp_bins[idx];
    end
    case (exp_state)
      IMG_PIXELS: r.status = ST_PIXELS;
      IMG_DONE:   r.status = ST_DONE;
      IMG_BAD:    r.status = ST_BAD;
      default:    r.status = ST_HEADER;
    endcase
    r.width   = exp_width;
    r.height  = exp_height;
    r.is_read = (m == MODE_READ);
    hist_reply_q.push_back(r);
  endtask

  // Drives one item and waits for its transfer. Called at a falling edge and
  // returns at a falling edge with valid still high, so back-to-back items
  // never drop valid in between. While idling the payload carries junk.
  task automatic send_item(input logic m, input logic [7:0] b, input logic s,
                           input logic e, input logic [7:0] idx);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid   <= 1'b0;
      mode       <= 1'($urandom);
      data_byte  <= 8'($urandom);
      file_start <= 1'($urandom);
      file_end   <= 1'($urandom);
      bin_index  <= 8'($urandom);
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    data_byte  <= b;
    file_start <= s;
    file_end   <= e;
    bin_index  <= idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_histogram(m, b, s, e, idx);
    sent_count++;
    @(negedge clk);
  endtask

  // A bin read; the file fields are ignored by the block, so they get junk.
  task automatic send_read(input logic [7:0] idx);
    send_item(MODE_READ, 8'($urandom), 1'($urandom), 1'($urandom), idx);
  endtask

  // Gray levels are drawn half the time from the two ends of the range, so
  // that bins fill up and reads return nonzero counts.
  function automatic logic [7:0] pick_gray();
    if ($urandom_range(0, 1) != 0) return 8'($urandom);
    return 8'($urandom_range(0, 3)) ^ (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
  endfunction

  // A byte that is neither a digit, a space nor a newline.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h2C;
      1:       return 8'h41;
      2:       return 8'h0D;
      default: return 8'h09;
    endcase
  endfunction

  // Sends the bytes in file_bytes as one file. The first byte starts the
  // file; file_end goes on the last one if asked. A noisy file also gets
  // bin reads between its bytes and the odd stray file start.
  task automatic send_file_bytes(input bit end_on_last, input bit noisy);
    int   last;
    logic start_bit;
    last = file_bytes.size() - 1;
    for (int i = 0; i <= last; i++) begin
      if (noisy && $urandom_range(0, 99) < 12) send_read(pick_gray());
      start_bit = (i == 0) || (noisy && $urandom_range(0, 59) == 0);
      send_item(MODE_FILE, file_bytes[i], start_bit, end_on_last && i == last,
                8'($urandom));
    end
  endtask

  // Appends one decimal size field and its ending byte. A huge field has
  // enough digits to overflow; its value is returned as the maximum.
  task automatic append_size(input bit huge, input logic [7:0] term, output int value);
    if (huge) begin
      repeat ($urandom_range(6, 7)) file_bytes.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
      value = (1 << DIM_W) - 1;
    end else begin
      value = $urandom_range(0, 4);
      if ($urandom_range(0, 4) == 0) file_bytes.push_back(noise_byte());
      if ($urandom_range(0, 3) == 0) file_bytes.push_back(CH_ZERO);
      // A zero size may also be written as no digits at all.
      if (value != 0 || $urandom_range(0, 1) != 0) file_bytes.push_back(CH_ZERO + 8'(value));
    end
    file_bytes.push_back(term);
  endtask

  // Builds and sends one random file. Most are well formed with small
  // sizes; some have a broken magic, a header cut short by end of file,
  // pixels cut short, trailing bytes after done, or a huge width.
  task automatic send_random_file();
    int   kind;
    int   w;
    int   h;
    int   total;
    int   n_pix;
    bit   end_flag;
    logic [7:0] b;
    file_bytes.delete();
    kind = $urandom_range(0, 99);
    file_bytes.push_back(CH_P);
    file_bytes.push_back(CH_FIVE);
    if (kind < 4) begin
      do b = 8'($urandom); while (b == CH_P);
      file_bytes[0] = b;
    end else if (kind < 8) begin
      do b = 8'($urandom); while (b == CH_FIVE);
      file_bytes[1] = b;
    end
    file_bytes.push_back(8'($urandom));
    append_size(kind >= 94, CH_SPACE, w);
    append_size(1'b0, CH_NEWLINE, h);
    if ($urandom_range(0, 1) != 0) begin
      file_bytes.push_back(CH_ZERO + 8'd2);
      file_bytes.push_back(CH_ZERO + 8'd5);
      file_bytes.push_back(CH_ZERO + 8'd5);
    end else begin
      repeat ($urandom_range(0, 3)) begin
        do b = 8'($urandom); while (b == CH_NEWLINE);
        file_bytes.push_back(b);
      end
    end
    file_bytes.push_back(CH_NEWLINE);

    if (kind >= 8 && kind < 16) begin
      // End of file somewhere inside the header, the magic included.
      file_bytes = file_bytes[0 : $urandom_range(0, file_bytes.size() - 1)];
      send_file_bytes(1'b1, 1'b1);
    end else begin
      total = w * h;
      end_flag = ($urandom_range(0, 1) != 0);
      if (total > 16) begin
        n_pix = $urandom_range(1, 10);
        end_flag = 1'b1;
      end else if (total > 0 && $urandom_range(0, 99) < 15) begin
        n_pix = $urandom_range(0, total - 1);
        end_flag = 1'b1;
      end else begin
        n_pix = total;
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
          n_pix = 0;
          total = 0;
        end
      end
      // Trailing bytes, when present, were pushed after the header above,
      // so pixels only go in when none were added.
      if (total > 0 || n_pix > 0)
        repeat (n_pix) file_bytes.push_back(pick_gray());
      send_file_bytes(end_flag, 1'b1);
    end
  endtask

  // Drops valid and holds off until every queued reply has been checked.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (hist_reply_q.size() != 0);
  endtask

  // Result monitor: outputs are sampled at the rising edge, before the
  // block's registers update.
  always @(posedge clk) begin
    hist_reply_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (hist_reply_q.size() == 0) begin
        log_fail("result transfer with no item outstanding");
      end else begin
        want = hist_reply_q.pop_front();
        if (status !== want.status)
          log_fail($sformatf("status %0d, expected %0d", status, want.status));
        if (image_width !== want.width)
          log_fail($sformatf("image_width %0d, expected %0d", image_width, want.width));
        if (image_height !== want.height)
          log_fail($sformatf("image_height %0d, expected %0d", image_height, want.height));
        if (bin_count !== want.count)
          log_fail($sformatf("bin_count %0d, expected %0d", bin_count, want.count));
        if (read_valid !== want.is_read)
          log_fail($sformatf("read_valid %b, expected %b", read_valid, want.is_read));
      end
    end
  end

  // Receiver: ready changes at the falling edge, with stalls at the rate
  // set by the current test phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Reads before any file see empty bins; read items ignore the file flags.
  task automatic test_reads_after_reset();
    send_item(MODE_READ, 8'hFF, 1'b1, 1'b1, 8'hFF);
    send_read(8'h00);
  endtask

  // 2x2 image with a non-digit inside the width, ended by end of file after
  // two pixels. A byte after done must be ignored, then both bins are read.
  task automatic test_small_image();
    file_bytes = '{CH_P, CH_FIVE, CH_NEWLINE, CH_ZERO + 8'd2, 8'h78, CH_SPACE,
                   CH_ZERO + 8'd2, CH_NEWLINE, CH_NEWLINE, 8'h00, 8'hFF};
    send_file_bytes(1'b1, 1'b0);
    send_item(MODE_FILE, 8'h07, 1'b0, 1'b0, 8'h00);
    send_read(8'h00);
    send_read(8'hFF);
  endtask

  // Empty width and an overflowing height: the product is zero, so the file
  // is done right after the max-value line. The new file cleared the bins.
  task automatic test_empty_image();
    file_bytes = '{CH_P, CH_FIVE, CH_SPACE, CH_SPACE};
    repeat (5) file_bytes.push_back(CH_NINE);
    file_bytes.push_back(CH_NEWLINE);
    file_bytes.push_back(CH_NEWLINE);
    send_file_bytes(1'b0, 1'b0);
    send_read(8'h00);
  endtask

  // Wrong first byte, wrong second byte, and end of file inside the magic.
  task automatic test_bad_magic();
    file_bytes = '{8'h51, CH_FIVE, CH_P};
    send_file_bytes(1'b0, 1'b0);
    file_bytes = '{CH_P, 8'h36};
    send_file_bytes(1'b0, 1'b0);
    file_bytes = '{CH_P};
    send_file_bytes(1'b1, 1'b0);
  endtask

  // End of file in the middle of the width: done, with the width so far.
  task automatic test_header_cut_short();
    file_bytes = '{CH_P, CH_FIVE, CH_SPACE, CH_ZERO + 8'd3};
    send_file_bytes(1'b1, 1'b0);
  endtask

  // Random files under one idle/stall setting, then a full drain.
  task automatic test_random_files(input int gap_pct, input int hold_pct, input int n_items);
    int stop_at;
    idle_pct  = gap_pct;
    stall_pct = hold_pct;
    stop_at   = sent_count + n_items;
    while (sent_count < stop_at) send_random_file();
    wait_results_drained();
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    mode       = MODE_FILE;
    data_byte  = '0;
    file_start = 1'b0;
    file_end   = 1'b0;
    bin_index  = '0;
    out_ready  = 1'b0;
    clear_file_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reads_after_reset();
    test_small_image();
    test_empty_image();
    test_bad_magic();
    test_header_cut_short();
    wait_results_drained();

    test_random_files(0, 0, 110);
    test_random_files(59, 0, 110);
    test_random_files(0, 59, 110);
    test_random_files(36, 36, 120);

    // Everything is in; let the pipeline settle so a stray extra result
    // would still be caught.
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("pgm_gray_histogram regression: pass");
    end else begin
      $display("pgm_gray_histogram regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/pgh_pkg.sv
sv/pgh_parser.sv
sv/pgh_bins.sv
sv/pgm_gray_histogram.sv
bench/tb_pgm_gray_histogram.sv
